// ===== hw/rtl/dqa_pkg.sv =====
// dqa_pkg: shared types, operation codes and saturation helpers for the
// dual quaternion accumulator. No dependencies.
package dqa_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FUNC_BITS     = 3;
  localparam int SUM_BITS      = WORD_BITS + 2;
  localparam int PROD_BITS     = 2 * WORD_BITS;

  localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 3'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_MUL   = 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_ADD   = 3'd2;
  localparam logic [FUNC_BITS-1:0] FUNC_SCALE = 3'd3;
  localparam logic [FUNC_BITS-1:0] FUNC_CONJ  = 3'd4;

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef logic signed [WORD_BITS-1:0] word_t;
  // element 0 is w, then x, y, z
  typedef logic [3:0][WORD_BITS-1:0] quat_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    word_t in_real_w;
    word_t in_real_x;
    word_t in_real_y;
    word_t in_real_z;
    word_t in_dual_w;
    word_t in_dual_x;
    word_t in_dual_y;
    word_t in_dual_z;
    word_t factor;
  } op_item_t;

  typedef struct packed {
    word_t out_real_w;
    word_t out_real_x;
    word_t out_real_y;
    word_t out_real_z;
    word_t out_dual_w;
    word_t out_dual_x;
    word_t out_dual_y;
    word_t out_dual_z;
  } acc_item_t;

  function automatic logic signed [SUM_BITS-1:0] ext_sum(input logic [WORD_BITS-1:0] w);
    return {{(SUM_BITS-WORD_BITS){w[WORD_BITS-1]}}, w};
  endfunction

  function automatic logic [WORD_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] v);
    logic [WORD_BITS-1:0] r;
    if (&v[SUM_BITS-1:WORD_BITS-1] || ~|v[SUM_BITS-1:WORD_BITS-1]) begin
      r = v[WORD_BITS-1:0];
    end else if (v[SUM_BITS-1]) begin
      r = WORD_MIN;
    end else begin
      r = WORD_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dqa_fx_mul.sv =====
// dqa_fx_mul: saturating fixed point product, floor shift by FRAC_BITS.
// Depends on dqa_pkg.
module dqa_fx_mul import dqa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  word_t a,
  input  word_t b,
  output word_t p
);

  logic signed [PROD_BITS-1:0] full;
  logic signed [PROD_BITS-1:0] shifted;

  assign full    = PROD_BITS'(a) * PROD_BITS'(b);
  assign shifted = full >>> FRAC_BITS;

  always_comb begin
    if (&shifted[PROD_BITS-1:WORD_BITS-1] || ~|shifted[PROD_BITS-1:WORD_BITS-1]) begin
      p = shifted[WORD_BITS-1:0];
    end else if (shifted[PROD_BITS-1]) begin
      p = WORD_MIN;
    end else begin
      p = WORD_MAX;
    end
  end

endmodule

// ===== hw/rtl/dqa_qmul.sv =====
// dqa_qmul: saturating Hamilton product p = a * b of two quaternions.
// Depends on dqa_pkg and dqa_fx_mul.
module dqa_qmul import dqa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  quat_t a,
  input  quat_t b,
  output quat_t p
);

  word_t m [4][4];

  for (genvar i = 0; i < 4; i++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      dqa_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .a(a[i]),
        .b(b[j]),
        .p(m[i][j])
      );
    end
  end

  assign p[0] = sat_sum(ext_sum(m[0][0]) - ext_sum(m[1][1])
                      - ext_sum(m[2][2]) - ext_sum(m[3][3]));
  assign p[1] = sat_sum(ext_sum(m[0][1]) + ext_sum(m[1][0])
                      + ext_sum(m[2][3]) - ext_sum(m[3][2]));
  assign p[2] = sat_sum(ext_sum(m[0][2]) + ext_sum(m[2][0])
                      + ext_sum(m[3][1]) - ext_sum(m[1][3]));
  assign p[3] = sat_sum(ext_sum(m[0][3]) + ext_sum(m[3][0])
                      + ext_sum(m[1][2]) - ext_sum(m[2][1]));

endmodule

// ===== hw/rtl/dqa_datapath.sv =====
// dqa_datapath: next accumulator value for one operation item.
// Depends on dqa_pkg, dqa_qmul and dqa_fx_mul.
module dqa_datapath import dqa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic [FUNC_BITS-1:0] func,
  input  quat_t                op_real,
  input  quat_t                op_dual,
  input  word_t                factor,
  input  quat_t                acc_real,
  input  quat_t                acc_dual,
  output quat_t                nxt_real,
  output quat_t                nxt_dual
);

  quat_t rr;
  quat_t rd;
  quat_t dr;
  quat_t sc_real;
  quat_t sc_dual;

  dqa_qmul #(.FRAC_BITS(FRAC_BITS)) u_rr (.a(acc_real), .b(op_real), .p(rr));
  dqa_qmul #(.FRAC_BITS(FRAC_BITS)) u_rd (.a(acc_real), .b(op_dual), .p(rd));
  dqa_qmul #(.FRAC_BITS(FRAC_BITS)) u_dr (.a(acc_dual), .b(op_real), .p(dr));

  for (genvar k = 0; k < 4; k++) begin : g_scale
    dqa_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_sr (.a(acc_real[k]), .b(factor), .p(sc_real[k]));
    dqa_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_sd (.a(acc_dual[k]), .b(factor), .p(sc_dual[k]));
  end

  always_comb begin
    nxt_real = acc_real;
    nxt_dual = acc_dual;
    case (func)
      FUNC_LOAD: begin
        nxt_real = op_real;
        nxt_dual = op_dual;
      end
      FUNC_MUL: begin
        nxt_real = rr;
        for (int k = 0; k < 4; k++) begin
          nxt_dual[k] = sat_sum(ext_sum(rd[k]) + ext_sum(dr[k]));
        end
      end
      FUNC_ADD: begin
        for (int k = 0; k < 4; k++) begin
          nxt_real[k] = sat_sum(ext_sum(acc_real[k]) + ext_sum(op_real[k]));
          nxt_dual[k] = sat_sum(ext_sum(acc_dual[k]) + ext_sum(op_dual[k]));
        end
      end
      FUNC_SCALE: begin
        nxt_real = sc_real;
        nxt_dual = sc_dual;
      end
      FUNC_CONJ: begin
        for (int k = 1; k < 4; k++) begin
          nxt_real[k] = sat_sum(-ext_sum(acc_real[k]));
        end
      end
      default: begin
        nxt_real = acc_real;
        nxt_dual = acc_dual;
      end
    endcase
  end

endmodule

// ===== hw/rtl/dual_quaternion_accumulator_top.sv =====
// dual_quaternion_accumulator_top: running dual quaternion with an input
// register and the accumulator as result register. Depends on dqa_pkg, dqa_datapath.
//
//   channel   valid      ready      payload
//   op        op_valid   op_ready   op  (op_item_t)
//   acc       acc_valid  acc_ready  acc (acc_item_t)
//
// one item per cycle sustained while acc_ready is high; an accepted item passes
// through the input register into the accumulator, which then shows it as the result
// the accumulator register holds the result; combinational products and sums
// forms the next value from the input register and the accumulator
// reset sets the accumulator to the identity and empties both stages
// a stalled result holds the accumulator; one further item waits in the
// input register before op_ready drops
module dual_quaternion_accumulator_top import dqa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_ready,
  input  op_item_t  op,
  output logic      acc_valid,
  input  logic      acc_ready,
  output acc_item_t acc
);

  localparam logic [WORD_BITS-1:0] ACC_ONE = WORD_BITS'(1) << FRAC_BITS;

  op_item_t op_q;
  logic     op_q_valid;
  logic     advance;
  quat_t    acc_real;
  quat_t    acc_dual;
  quat_t    op_real;
  quat_t    op_dual;
  quat_t    acc_real_next;
  quat_t    acc_dual_next;

  assign advance  = op_q_valid && (!acc_valid || acc_ready);
  assign op_ready = !op_q_valid || advance;

  assign op_real = {op_q.in_real_z, op_q.in_real_y, op_q.in_real_x, op_q.in_real_w};
  assign op_dual = {op_q.in_dual_z, op_q.in_dual_y, op_q.in_dual_x, op_q.in_dual_w};

  dqa_datapath #(.FRAC_BITS(FRAC_BITS)) u_datapath (
    .func     (op_q.func),
    .op_real  (op_real),
    .op_dual  (op_dual),
    .factor   (op_q.factor),
    .acc_real (acc_real),
    .acc_dual (acc_dual),
    .nxt_real (acc_real_next),
    .nxt_dual (acc_dual_next)
  );

  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      op_q <= op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q_valid <= 1'b0;
      acc_valid  <= 1'b0;
      acc_real   <= {{3{WORD_BITS'(0)}}, ACC_ONE};
      acc_dual   <= '0;
    end else begin
      if (op_valid && op_ready) begin
        op_q_valid <= 1'b1;
      end else if (advance) begin
        op_q_valid <= 1'b0;
      end
      if (advance) begin
        acc_valid <= 1'b1;
        acc_real  <= acc_real_next;
        acc_dual  <= acc_dual_next;
      end else if (acc_ready) begin
        acc_valid <= 1'b0;
      end
    end
  end

  assign acc.out_real_w = acc_real[0];
  assign acc.out_real_x = acc_real[1];
  assign acc.out_real_y = acc_real[2];
  assign acc.out_real_z = acc_real[3];
  assign acc.out_dual_w = acc_dual[0];
  assign acc.out_dual_x = acc_dual[1];
  assign acc.out_dual_y = acc_dual[2];
  assign acc.out_dual_z = acc_dual[3];

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> acc_valid)
    else $error("stepped item not shown as result");

  a_acc_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(acc_real) && $stable(acc_dual))
    else $error("accumulator changed without a step");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !op_ready |-> op_q_valid && acc_valid && !acc_ready)
    else $error("input stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !acc_valid && !op_q_valid)
    else $error("stages not empty after reset");

endmodule

// ===== sim/dqa_acc_checker.sv =====
`timescale 1ns / 100ps
// dqa_acc_checker: watches the op and acc channels of dual_quaternion_accumulator_top,
// predicts every accumulator item and compares it field by field.
// Depends on dqa_pkg.
module dqa_acc_checker import dqa_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  input  logic      op_ready,
  input  op_item_t  op,
  input  logic      acc_valid,
  input  logic      acc_ready,
  input  acc_item_t acc,
  output int        outstanding,
  output int        mismatches
);

  localparam longint W_HI = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint W_LO = -W_HI - 1;

  typedef word_t quad_t [4];

  quad_t acc_re;
  quad_t acc_du;
  acc_item_t expected_accs[$];

  function automatic word_t clamp_word(input longint v);
    word_t r;
    if (v > W_HI) begin
      r = word_t'(W_HI);
    end else if (v < W_LO) begin
      r = word_t'(W_LO);
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

  // exact product, floor shift, then saturate
  function automatic longint fx_prod(input word_t a, input word_t b);
    longint p;
    p = longint'(a) * longint'(b);
    return longint'(clamp_word(p >>> FRAC_BITS));
  endfunction

  function automatic quad_t hamilton(input quad_t a, input quad_t b);
    quad_t p;
    p[0] = clamp_word(fx_prod(a[0], b[0]) - fx_prod(a[1], b[1])
                      - fx_prod(a[2], b[2]) - fx_prod(a[3], b[3]));
    p[1] = clamp_word(fx_prod(a[0], b[1]) + fx_prod(a[1], b[0])
                      + fx_prod(a[2], b[3]) - fx_prod(a[3], b[2]));
    p[2] = clamp_word(fx_prod(a[0], b[2]) + fx_prod(a[2], b[0])
                      + fx_prod(a[3], b[1]) - fx_prod(a[1], b[3]));
    p[3] = clamp_word(fx_prod(a[0], b[3]) + fx_prod(a[3], b[0])
                      + fx_prod(a[1], b[2]) - fx_prod(a[2], b[1]));
    return p;
  endfunction

  function automatic acc_item_t step_accumulator(input op_item_t o);
    quad_t br;
    quad_t bd;
    quad_t nr;
    quad_t nd;
    quad_t t1;
    quad_t t2;
    acc_item_t r;
    br = '{o.in_real_w, o.in_real_x, o.in_real_y, o.in_real_z};
    bd = '{o.in_dual_w, o.in_dual_x, o.in_dual_y, o.in_dual_z};
    nr = acc_re;
    nd = acc_du;
    case (o.func)
      FUNC_LOAD: begin
        nr = br;
        nd = bd;
      end
      FUNC_MUL: begin
        nr = hamilton(acc_re, br);
        t1 = hamilton(acc_re, bd);
        t2 = hamilton(acc_du, br);
        for (int i = 0; i < 4; i++) nd[i] = clamp_word(longint'(t1[i]) + longint'(t2[i]));
      end
      FUNC_ADD: begin
        for (int i = 0; i < 4; i++) begin
          nr[i] = clamp_word(longint'(acc_re[i]) + longint'(br[i]));
          nd[i] = clamp_word(longint'(acc_du[i]) + longint'(bd[i]));
        end
      end
      FUNC_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          nr[i] = word_t'(fx_prod(acc_re[i], o.factor));
          nd[i] = word_t'(fx_prod(acc_du[i], o.factor));
        end
      end
      FUNC_CONJ: begin
        for (int i = 1; i < 4; i++) nr[i] = clamp_word(-longint'(acc_re[i]));
      end
      default: begin
      end
    endcase
    acc_re = nr;
    acc_du = nd;
    r.out_real_w = nr[0];
    r.out_real_x = nr[1];
    r.out_real_y = nr[2];
    r.out_real_z = nr[3];
    r.out_dual_w = nd[0];
    r.out_dual_x = nd[1];
    r.out_dual_y = nd[2];
    r.out_dual_z = nd[3];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t acc mismatch: %s", $time, msg);
  endtask

  task automatic check_acc(input acc_item_t got, input acc_item_t want);
    logic [7:0][WORD_BITS-1:0] g;
    logic [7:0][WORD_BITS-1:0] w;
    string names [8] = '{"real_w", "real_x", "real_y", "real_z",
                         "dual_w", "dual_x", "dual_y", "dual_z"};
    g = got;
    w = want;
    for (int i = 0; i < 8; i++) begin
      if (g[7-i] !== w[7-i]) begin
        report_mismatch($sformatf("%s got %h want %h", names[i], g[7-i], w[7-i]));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc_re = '{word_t'(longint'(1) <<< FRAC_BITS), '0, '0, '0};
      acc_du = '{default: '0};
      expected_accs.delete();
    end else begin
      if (acc_valid && acc_ready) begin
        if (expected_accs.size() == 0) begin
          report_mismatch("item with no expectation waiting");
        end else begin
          check_acc(acc, expected_accs.pop_front());
        end
      end
      if (op_valid && op_ready) begin
        expected_accs.push_back(step_accumulator(op));
      end
    end
    outstanding <= expected_accs.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// tb: stimulus and verdict for dual_quaternion_accumulator_top; checking is
// done by dqa_acc_checker. Depends on dqa_pkg, dqa_acc_checker and the RTL.
module tb;
  import dqa_pkg::*;

  localparam logic [FUNC_BITS-1:0] FUNC_NOP_LO = FUNC_CONJ + 3'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_NOP_HI = '1;
  localparam word_t W_MAX  = WORD_MAX;
  localparam word_t W_MIN  = WORD_MIN;
  localparam word_t Q_ONE  = word_t'(1 << FRAC_BITS_DEF);
  localparam word_t Q_HALF = word_t'(1 << (FRAC_BITS_DEF - 1));
  localparam int PHASE_ITEMS = 650;
  localparam int HOLD_CYCLES = 60;

  logic      clk = 1'b0;
  logic      rst;
  logic      op_valid;
  logic      op_ready;
  op_item_t  op;
  logic      acc_valid;
  logic      acc_ready;
  acc_item_t acc;
  int        outstanding;
  int        mismatches;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        hold_reqs = 0;

  always #6 clk = ~clk;

  dual_quaternion_accumulator_top #(.FRAC_BITS(FRAC_BITS_DEF)) u_top (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_ready  (op_ready),
    .op        (op),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc       (acc)
  );

  dqa_acc_checker #(.FRAC_BITS(FRAC_BITS_DEF)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (op_valid),
    .op_ready    (op_ready),
    .op          (op),
    .acc_valid   (acc_valid),
    .acc_ready   (acc_ready),
    .acc         (acc),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  function automatic op_item_t mk_op(input logic [FUNC_BITS-1:0] f,
                                     input word_t rw, rx, ry, rz, dw, dx, dy, dz, fac);
    op_item_t o;
    o.func      = f;
    o.in_real_w = rw;
    o.in_real_x = rx;
    o.in_real_y = ry;
    o.in_real_z = rz;
    o.in_dual_w = dw;
    o.in_dual_x = dx;
    o.in_dual_y = dy;
    o.in_dual_z = dz;
    o.factor    = fac;
    return o;
  endfunction

  // mostly small values near unity so products stay in range
  function automatic word_t rand_word();
    word_t v;
    case ($urandom_range(0, 9))
      0, 1: begin
        v = word_t'($urandom);
      end
      2: begin
        case ($urandom_range(0, 4))
          0: v = W_MAX;
          1: v = W_MIN;
          2: v = '0;
          3: v = '1;
          default: v = Q_ONE;
        endcase
      end
      default: begin
        v = word_t'(int'($urandom_range(0, 262144)) - 131072);
      end
    endcase
    return v;
  endfunction

  function automatic op_item_t rand_op();
    op_item_t o;
    int r;
    o = mk_op(FUNC_LOAD, rand_word(), rand_word(), rand_word(), rand_word(),
              rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    r = $urandom_range(0, 99);
    if (r < 15) begin
      o.func = FUNC_LOAD;
    end else if (r < 50) begin
      o.func = FUNC_MUL;
    end else if (r < 68) begin
      o.func = FUNC_ADD;
    end else if (r < 82) begin
      o.func = FUNC_SCALE;
    end else if (r < 94) begin
      o.func = FUNC_CONJ;
    end else begin
      o.func = FUNC_BITS'($urandom_range(FUNC_NOP_LO, FUNC_NOP_HI));
    end
    return o;
  endfunction

  task automatic send_op(input op_item_t item);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      op_valid <= 1'b0;
      @(posedge clk);
    end
    op       <= item;
    op_valid <= 1'b1;
    @(posedge clk);
    while (!op_ready) @(posedge clk);
  endtask

  // result side: random stalls plus a long hold-off on request
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    acc_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        acc_ready <= 1'b0;
        hold_left--;
      end else begin
        acc_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #6_000_000;
    $display("dual_quaternion_accumulator_top regression: fail");
    $finish;
  end

  initial begin
    int tx_pcts [3];
    int rx_pcts [3];
    tx_pcts = '{26, 88, 0};
    rx_pcts = '{88, 26, 0};
    rst      <= 1'b1;
    op_valid <= 1'b0;
    op       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset value, saturation at both ends, floor rounding, spare codes
    send_op(mk_op(FUNC_NOP_LO, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
    send_op(mk_op(FUNC_NOP_HI, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN));
    send_op(mk_op(FUNC_LOAD, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, '0));
    send_op(mk_op(FUNC_ADD, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, '0));
    send_op(mk_op(FUNC_CONJ, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_op(mk_op(FUNC_LOAD, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, '0));
    send_op(mk_op(FUNC_CONJ, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX));
    send_op(mk_op(FUNC_ADD, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, '0));
    send_op(mk_op(FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0, '0, W_MIN));
    send_op(mk_op(FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0, '0, W_MAX));
    send_op(mk_op(FUNC_LOAD, Q_ONE, '0, '0, '0, '0, Q_ONE, 2 * Q_ONE, -Q_ONE, '0));
    send_op(mk_op(FUNC_MUL, Q_HALF, Q_HALF, Q_HALF, Q_HALF, Q_ONE, -Q_HALF, '0, Q_HALF, '0));
    send_op(mk_op(FUNC_MUL, Q_HALF, Q_HALF, Q_HALF, Q_HALF, Q_ONE, -Q_HALF, '0, Q_HALF, '0));
    send_op(mk_op(FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0, '0, Q_HALF));
    send_op(mk_op(FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0, '0, -Q_ONE));
    send_op(mk_op(FUNC_CONJ, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_op(mk_op(FUNC_ADD, 3, -5, Q_HALF, -Q_HALF, -7, 11, -Q_ONE, Q_ONE, '0));
    send_op(mk_op(FUNC_LOAD, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_op(mk_op(FUNC_MUL, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    send_op(mk_op(FUNC_LOAD, 32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0000,
                  -32'sh4000_0000, 32'sh7fff_0000, 32'sh0001_8000, -32'sh0001_8000, 1, '0));
    send_op(mk_op(FUNC_MUL, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, '0));
    send_op(mk_op(FUNC_MUL, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, '0));
    send_op(mk_op(FUNC_SCALE, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    send_op(mk_op(FUNC_LOAD, W_MAX, W_MIN, '0, '1, W_MIN, W_MAX, '1, '0, '0));

    for (int p = 0; p < 3; p++) begin
      tx_idle_pct = tx_pcts[p];
      rx_idle_pct = rx_pcts[p];
      // in the last phase, fill the block while the result side is held off
      if (p == 2) hold_reqs++;
      for (int n = 0; n < PHASE_ITEMS; n++) send_op(rand_op());
    end
    op_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("dual_quaternion_accumulator_top regression: pass");
    end else begin
      $display("dual_quaternion_accumulator_top regression: fail");
    end
    $finish;
  end

endmodule
